FILE: src/dtbs_pkg.sv
// ----------------------------------------------------------------------------
// dtbs_pkg - shared definitions for the dual token bucket shaper
// Field widths, fixed point format, request and result codes, CSR map and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package dtbs_pkg;

   // Field widths
   localparam int HANDLE_W    = 32;
   localparam int LEN_W       = 10;
   localparam int ELAPSED_W   = 16;
   localparam int OP_W        = 2;
   localparam int KIND_W      = 3;
   localparam int COUNT_W     = 6;
   localparam int MSG_SIZE_W  = 6;
   localparam int CHAR_SIZE_W = 16;
   localparam int RATE_W      = 24;

   // Token accumulators, unsigned Q16
   localparam int FRAC_W      = 16;
   localparam int MSG_TOK_W   = 22;
   localparam int CHAR_TOK_W  = 32;
   localparam int PROD_W      = ELAPSED_W + RATE_W;
   localparam int SUM_W       = PROD_W + 1;

   // Queue and flush limits
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int MAX_MSG_LEN     = 512;
   localparam int MAX_EVENTS      = 32;
   localparam int EVENT_W         = 6;

   // CSR port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_MSG_BUCKET_SIZE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_BUCKET_SIZE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MSG_BURST        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_BURST       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MSG_RATE         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_RATE        = 3'd5;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_FLUSH   = 2'd1;
   localparam logic [OP_W-1:0] OP_START   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SENT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;

   // Configuration reset values
   localparam logic [MSG_SIZE_W-1:0]  MSG_BUCKET_SIZE_RST  = 6'd16;
   localparam logic [CHAR_SIZE_W-1:0] CHAR_BUCKET_SIZE_RST = 16'd4096;
   localparam logic [MSG_SIZE_W-1:0]  MSG_BURST_RST        = 6'd4;
   localparam logic [CHAR_SIZE_W-1:0] CHAR_BURST_RST       = 16'd1024;
   localparam logic [RATE_W-1:0]      MSG_RATE_RST         = 24'd65;
   localparam logic [RATE_W-1:0]      CHAR_RATE_RST        = 24'd6554;

   // One whole message token and the token reset values
   localparam logic [MSG_TOK_W-1:0]  MSG_TOK_ONE  = 22'h01_0000;
   localparam logic [MSG_TOK_W-1:0]  MSG_TOK_RST  = {MSG_BURST_RST, {FRAC_W{1'b0}}};
   localparam logic [CHAR_TOK_W-1:0] CHAR_TOK_RST = {CHAR_BURST_RST, {FRAC_W{1'b0}}};

endpackage

FILE: src/dual_token_bucket_shaper.sv
// ----------------------------------------------------------------------------
// dual_token_bucket_shaper - message queue shaped by two token buckets
// Queues message handles and lengths in a RAM; a flush refills a message
// bucket and a character bucket, drops oversize heads and sends heads while
// tokens last.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   op, msg_handle, msg_len, elapsed_ms
//   rsp      out        rsp_valid/rsp_stall   kind, out_handle, out_len,
//                                             queued_count, last
//   csr      in         csr_valid/csr_ready   index, wdata
//
// Enqueue, start and clear put their result in the output register from
// ST_EXEC, which waits while rsp_stall holds the output register.
// Flush walks ST_EXEC, ST_MUL, ST_REFILL, then ST_READ and ST_CHECK per head
// examined (RAM read, then decision): each head that leaves, and one that stays.
// One request is in work at a time; the next is taken once the last result
// sits in the output register, even while rsp_stall holds it.
// Reset is synchronous; the queue RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module dual_token_bucket_shaper #(
   parameter int QUEUE_DEPTH = dtbs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dtbs_pkg::OP_W-1:0]           req_op,
   input  logic [dtbs_pkg::HANDLE_W-1:0]       req_msg_handle,
   input  logic [dtbs_pkg::LEN_W-1:0]          req_msg_len,
   input  logic [dtbs_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dtbs_pkg::KIND_W-1:0]         rsp_kind,
   output logic [dtbs_pkg::HANDLE_W-1:0]       rsp_out_handle,
   output logic [dtbs_pkg::LEN_W-1:0]          rsp_out_len,
   output logic [dtbs_pkg::COUNT_W-1:0]        rsp_queued_count,
   output logic                                rsp_last,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dtbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dtbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W  = dtbs_pkg::HANDLE_W + dtbs_pkg::LEN_W;
   localparam int HANDLE_W = dtbs_pkg::HANDLE_W;
   localparam int LEN_W    = dtbs_pkg::LEN_W;
   localparam int COUNT_W  = dtbs_pkg::COUNT_W;
   localparam int MTOK_W   = dtbs_pkg::MSG_TOK_W;
   localparam int CTOK_W   = dtbs_pkg::CHAR_TOK_W;
   localparam int SUM_W    = dtbs_pkg::SUM_W;
   localparam int PROD_W   = dtbs_pkg::PROD_W;
   localparam int FRAC_W   = dtbs_pkg::FRAC_W;
   localparam int EVENT_W  = dtbs_pkg::EVENT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_REFILL,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [dtbs_pkg::MSG_SIZE_W-1:0]  msg_size_ff;
   logic [dtbs_pkg::CHAR_SIZE_W-1:0] char_size_ff;
   logic [dtbs_pkg::MSG_SIZE_W-1:0]  msg_burst_ff;
   logic [dtbs_pkg::CHAR_SIZE_W-1:0] char_burst_ff;
   logic [dtbs_pkg::RATE_W-1:0]      msg_rate_ff;
   logic [dtbs_pkg::RATE_W-1:0]      char_rate_ff;

   assign csr_ready = 1'b1;

   // Take register writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         msg_size_ff   <= dtbs_pkg::MSG_BUCKET_SIZE_RST;
         char_size_ff  <= dtbs_pkg::CHAR_BUCKET_SIZE_RST;
         msg_burst_ff  <= dtbs_pkg::MSG_BURST_RST;
         char_burst_ff <= dtbs_pkg::CHAR_BURST_RST;
         msg_rate_ff   <= dtbs_pkg::MSG_RATE_RST;
         char_rate_ff  <= dtbs_pkg::CHAR_RATE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dtbs_pkg::CSR_MSG_BUCKET_SIZE: begin
               msg_size_ff <= csr_wdata[dtbs_pkg::MSG_SIZE_W-1:0];
            end
            dtbs_pkg::CSR_CHAR_BUCKET_SIZE: begin
               char_size_ff <= csr_wdata[dtbs_pkg::CHAR_SIZE_W-1:0];
            end
            dtbs_pkg::CSR_MSG_BURST: begin
               msg_burst_ff <= csr_wdata[dtbs_pkg::MSG_SIZE_W-1:0];
            end
            dtbs_pkg::CSR_CHAR_BURST: begin
               char_burst_ff <= csr_wdata[dtbs_pkg::CHAR_SIZE_W-1:0];
            end
            dtbs_pkg::CSR_MSG_RATE: begin
               msg_rate_ff <= csr_wdata;
            end
            dtbs_pkg::CSR_CHAR_RATE: begin
               char_rate_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Request capture and refill products
   // ------------------------------------------------------------------------
   logic [dtbs_pkg::OP_W-1:0]      op_ff;
   logic [HANDLE_W-1:0]            handle_ff;
   logic [LEN_W-1:0]               len_ff;
   logic [dtbs_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic [PROD_W-1:0]              msg_prod_ff;
   logic [PROD_W-1:0]              char_prod_ff;
   logic                           req_take;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Hold the request; form elapsed times rate in a register, used in ST_REFILL
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= req_op;
         handle_ff  <= req_msg_handle;
         len_ff     <= req_msg_len;
         elapsed_ff <= req_elapsed_ms;
      end
      msg_prod_ff  <= PROD_W'(elapsed_ff) * PROD_W'(msg_rate_ff);
      char_prod_ff <= PROD_W'(elapsed_ff) * PROD_W'(char_rate_ff);
   end

   // ------------------------------------------------------------------------
   // Queue RAM: handle in the upper bits, length in the lower bits
   // ------------------------------------------------------------------------
   logic               ram_we;
   logic [PTR_W-1:0]   ram_waddr;
   logic               ram_re;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [PTR_W-1:0]   head_ff, head_in;

   dtbs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({handle_ff, len_ff}),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------------
   // Control and datapath
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0]               count_ff, count_in;
   logic [dtbs_pkg::CHAR_SIZE_W-1:0] chars_ff, chars_in;
   logic [MTOK_W-1:0]                msg_tok_ff, msg_tok_in;
   logic [CTOK_W-1:0]                char_tok_ff, char_tok_in;
   logic [EVENT_W-1:0]               events_ff, events_in;
   logic                             send_phase_ff, send_phase_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dtbs_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0]              rsp_handle_ff, rsp_handle_in;
   logic [LEN_W-1:0]                 rsp_len_ff, rsp_len_in;
   logic [COUNT_W-1:0]               rsp_count_ff, rsp_count_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             out_free;
   logic                             enq_ok;
   logic [PTR_W:0]                   tail_sum;
   logic [PTR_W-1:0]                 head_next;
   logic [HANDLE_W-1:0]              rd_handle;
   logic [LEN_W-1:0]                 rd_len;
   logic [CTOK_W-1:0]                rd_cost;
   logic                             drop_hit;
   logic                             send_ok;
   logic [SUM_W-1:0]                 msg_sum;
   logic [SUM_W-1:0]                 msg_cap;
   logic [SUM_W-1:0]                 char_sum;
   logic [SUM_W-1:0]                 char_cap;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Tail slot: head plus count, wrapped once
   assign tail_sum  = (PTR_W+1)'(head_ff) + (PTR_W+1)'(count_ff);
   assign ram_waddr = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH))
                      : PTR_W'(tail_sum);
   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Admission check for an enqueue
   assign enq_ok = (len_ff != '0)
                   && (32'(len_ff) <= 32'(dtbs_pkg::MAX_MSG_LEN))
                   && (32'(count_ff) < 32'(QUEUE_DEPTH))
                   && ((COUNT_W+1)'(count_ff) + 1'b1 <= (COUNT_W+1)'(msg_size_ff))
                   && (17'(chars_ff) + 17'(len_ff) <= 17'(char_size_ff));

   // Head entry and its flush decisions
   assign rd_handle = ram_rdata[ENTRY_W-1:LEN_W];
   assign rd_len    = ram_rdata[LEN_W-1:0];
   assign rd_cost   = CTOK_W'({rd_len, {FRAC_W{1'b0}}});
   assign drop_hit  = !send_phase_ff && (dtbs_pkg::CHAR_SIZE_W'(rd_len) > char_burst_ff);
   assign send_ok   = (msg_tok_ff >= dtbs_pkg::MSG_TOK_ONE) && (rd_cost <= char_tok_ff);

   // Refill sums and caps
   assign msg_sum  = SUM_W'(msg_tok_ff) + SUM_W'(msg_prod_ff);
   assign msg_cap  = SUM_W'({msg_size_ff, {FRAC_W{1'b0}}});
   assign char_sum = SUM_W'(char_tok_ff) + SUM_W'(char_prod_ff);
   assign char_cap = SUM_W'({char_size_ff, {FRAC_W{1'b0}}});

   // Next state and result
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      chars_in      = chars_ff;
      msg_tok_in    = msg_tok_ff;
      char_tok_in   = char_tok_ff;
      events_in     = events_ff;
      send_phase_in = send_phase_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (op_ff)
               dtbs_pkg::OP_ENQUEUE: begin
                  if (out_free) begin
                     if (enq_ok) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                        chars_in = chars_ff + dtbs_pkg::CHAR_SIZE_W'(len_ff);
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = enq_ok ? dtbs_pkg::KIND_ACCEPTED
                                            : dtbs_pkg::KIND_REJECTED;
                     rsp_handle_in = '0;
                     rsp_len_in    = '0;
                     rsp_count_in  = count_in;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               dtbs_pkg::OP_FLUSH: begin
                  state_in = ST_MUL;
               end
               default: begin
                  // start and clear: empty the queue, start also reloads bursts
                  if (out_free) begin
                     head_in  = '0;
                     count_in = '0;
                     chars_in = '0;
                     if (op_ff == dtbs_pkg::OP_START) begin
                        msg_tok_in  = MTOK_W'({msg_burst_ff, {FRAC_W{1'b0}}});
                        char_tok_in = CTOK_W'({char_burst_ff, {FRAC_W{1'b0}}});
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = dtbs_pkg::KIND_DONE;
                     rsp_handle_in = '0;
                     rsp_len_in    = '0;
                     rsp_count_in  = count_in;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            endcase
         end

         ST_MUL: begin
            // products settle into msg_prod_ff and char_prod_ff
            state_in = ST_REFILL;
         end

         ST_REFILL: begin
            // add elapsed tokens, saturate at the bucket size
            msg_tok_in    = (msg_sum < msg_cap) ? MTOK_W'(msg_sum) : MTOK_W'(msg_cap);
            char_tok_in   = (char_sum < char_cap) ? CTOK_W'(char_sum) : CTOK_W'(char_cap);
            events_in     = '0;
            send_phase_in = 1'b0;
            state_in      = ST_READ;
         end

         ST_READ: begin
            if ((count_ff == '0) || (events_ff == EVENT_W'(dtbs_pkg::MAX_EVENTS))) begin
               state_in = ST_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (drop_hit) begin
               // drop an oversize head
               if (out_free) begin
                  head_in       = head_next;
                  count_in      = count_ff - 1'b1;
                  chars_in      = chars_ff - dtbs_pkg::CHAR_SIZE_W'(rd_len);
                  events_in     = events_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = dtbs_pkg::KIND_DROPPED;
                  rsp_handle_in = rd_handle;
                  rsp_len_in    = rd_len;
                  rsp_count_in  = count_in;
                  rsp_last_in   = 1'b0;
                  state_in      = ST_READ;
               end
            end else if (send_ok) begin
               // send the head and spend its tokens
               if (out_free) begin
                  send_phase_in = 1'b1;
                  msg_tok_in    = msg_tok_ff - dtbs_pkg::MSG_TOK_ONE;
                  char_tok_in   = char_tok_ff - rd_cost;
                  head_in       = head_next;
                  count_in      = count_ff - 1'b1;
                  chars_in      = chars_ff - dtbs_pkg::CHAR_SIZE_W'(rd_len);
                  events_in     = events_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = dtbs_pkg::KIND_SENT;
                  rsp_handle_in = rd_handle;
                  rsp_len_in    = rd_len;
                  rsp_count_in  = count_in;
                  rsp_last_in   = 1'b0;
                  state_in      = ST_READ;
               end
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dtbs_pkg::KIND_DONE;
               rsp_handle_in = '0;
               rsp_len_in    = '0;
               rsp_count_in  = count_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, queue bookkeeping, tokens and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         chars_ff      <= '0;
         msg_tok_ff    <= dtbs_pkg::MSG_TOK_RST;
         char_tok_ff   <= dtbs_pkg::CHAR_TOK_RST;
         events_ff     <= '0;
         send_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         chars_ff      <= chars_in;
         msg_tok_ff    <= msg_tok_in;
         char_tok_ff   <= char_tok_in;
         events_ff     <= events_in;
         send_phase_ff <= send_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_out_len      = rsp_len_ff;
   assign rsp_queued_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < 32'(QUEUE_DEPTH))
      else $error("head pointer out of range");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(count_ff) < 32'(QUEUE_DEPTH)) && (state_ff == ST_EXEC))
      else $error("queue write without room");

   a_event_limit: assert property (@(posedge clock) disable iff (reset)
      32'(events_ff) <= 32'(dtbs_pkg::MAX_EVENTS))
      else $error("flush handled too many messages");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start");

endmodule

FILE: src/dtbs_ram.sv
// ----------------------------------------------------------------------------
// dtbs_ram - generic single write port, single read port RAM
// Synchronous write, registered read with read enable; read data holds while
// the read enable is low.
// ----------------------------------------------------------------------------
module dtbs_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb_dual_token_bucket_shaper.sv
// ----------------------------------------------------------------------------
// tb_dual_token_bucket_shaper - self-checking bench for the token bucket shaper
// Drives enqueue, flush, start and clear requests through several register
// settings, predicts every result from a behavioral copy of the queue and
// both token buckets, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb_dual_token_bucket_shaper;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_AT     = 50;
   localparam int HOLD_LEN    = 300;
   localparam int QDEPTH      = dtbs_pkg::QUEUE_DEPTH_DEF;

   localparam int OP_W        = dtbs_pkg::OP_W;
   localparam int HANDLE_W    = dtbs_pkg::HANDLE_W;
   localparam int LEN_W       = dtbs_pkg::LEN_W;
   localparam int ELAPSED_W   = dtbs_pkg::ELAPSED_W;
   localparam int KIND_W      = dtbs_pkg::KIND_W;
   localparam int COUNT_W     = dtbs_pkg::COUNT_W;
   localparam int MSG_SIZE_W  = dtbs_pkg::MSG_SIZE_W;
   localparam int CHAR_SIZE_W = dtbs_pkg::CHAR_SIZE_W;
   localparam int RATE_W      = dtbs_pkg::RATE_W;
   localparam int MSG_TOK_W   = dtbs_pkg::MSG_TOK_W;
   localparam int CHAR_TOK_W  = dtbs_pkg::CHAR_TOK_W;
   localparam int FRAC_W      = dtbs_pkg::FRAC_W;
   localparam int CSR_INDEX_W = dtbs_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = dtbs_pkg::CSR_DATA_W;
   localparam int MAX_MSG_LEN = dtbs_pkg::MAX_MSG_LEN;
   localparam int MAX_EVENTS  = dtbs_pkg::MAX_EVENTS;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [HANDLE_W-1:0]  handle;
      logic [LEN_W-1:0]     len;
      logic [ELAPSED_W-1:0] elapsed;
   } shaper_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    len;
      logic [COUNT_W-1:0]  queued;
      logic                last;
   } shaper_evt_type;

   // DUT connections
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_op = dtbs_pkg::OP_ENQUEUE;
   logic [HANDLE_W-1:0]    req_msg_handle = '0;
   logic [LEN_W-1:0]       req_msg_len = '0;
   logic [ELAPSED_W-1:0]   req_elapsed_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_W-1:0]      rsp_kind;
   logic [HANDLE_W-1:0]    rsp_out_handle;
   logic [LEN_W-1:0]       rsp_out_len;
   logic [COUNT_W-1:0]     rsp_queued_count;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus and scoreboard state
   shaper_req_type request_backlog[$];
   shaper_evt_type predicted_events[$];
   shaper_req_type staged_req;
   int          reqs_issued = 0;
   int          reqs_accepted = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   bit          hold_spent = 1'b0;
   bit          req_taken = 1'b0;

   // Shaper shadow: configuration, queue and token buckets
   logic [MSG_SIZE_W-1:0]  cfg_msg_size   = dtbs_pkg::MSG_BUCKET_SIZE_RST;
   logic [CHAR_SIZE_W-1:0] cfg_char_size  = dtbs_pkg::CHAR_BUCKET_SIZE_RST;
   logic [MSG_SIZE_W-1:0]  cfg_msg_burst  = dtbs_pkg::MSG_BURST_RST;
   logic [CHAR_SIZE_W-1:0] cfg_char_burst = dtbs_pkg::CHAR_BURST_RST;
   logic [RATE_W-1:0]      cfg_msg_rate   = dtbs_pkg::MSG_RATE_RST;
   logic [RATE_W-1:0]      cfg_char_rate  = dtbs_pkg::CHAR_RATE_RST;
   logic [HANDLE_W-1:0]    q_handle[QDEPTH];
   logic [LEN_W-1:0]       q_len[QDEPTH];
   logic [4:0]             q_head = '0;
   int                     q_entries = 0;
   int                     q_chars = 0;
   logic [MSG_TOK_W-1:0]   msg_tok = dtbs_pkg::MSG_TOK_RST;
   logic [CHAR_TOK_W-1:0]  char_tok = dtbs_pkg::CHAR_TOK_RST;

   dual_token_bucket_shaper uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_msg_handle   (req_msg_handle),
      .req_msg_len      (req_msg_len),
      .req_elapsed_ms   (req_elapsed_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_out_len      (rsp_out_len),
      .rsp_queued_count (rsp_queued_count),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dual_token_bucket_shaper verification failed");
         $finish;
      end
   end

   // Add elapsed time times rate, saturate at the bucket size in Q16
   function automatic logic [63:0] refill_tokens(input logic [63:0] tokens,
                                                 input logic [63:0] rate,
                                                 input logic [63:0] ms,
                                                 input logic [63:0] size);
      logic [63:0] sum;
      logic [63:0] cap;
      sum = tokens + ms * rate;
      cap = size << FRAC_W;
      return (sum < cap) ? sum : cap;
   endfunction

   function automatic void post_event(input logic [KIND_W-1:0] kind,
                                      input logic [HANDLE_W-1:0] handle,
                                      input logic [LEN_W-1:0] len,
                                      input logic last);
      shaper_evt_type evt;
      evt.kind   = kind;
      evt.handle = handle;
      evt.len    = len;
      evt.queued = q_entries[COUNT_W-1:0];
      evt.last   = last;
      predicted_events.push_back(evt);
   endfunction

   // Advance the shadow shaper by one request and queue its results
   function automatic void shape_request(input shaper_req_type r);
      bit                  fits;
      int                  events;
      logic [4:0]          tail;
      logic [HANDLE_W-1:0] h;
      logic [LEN_W-1:0]    l;
      logic [63:0]         cost;
      case (r.op)
         dtbs_pkg::OP_ENQUEUE: begin
            fits = int'(r.len) != 0 && int'(r.len) <= MAX_MSG_LEN && q_entries < QDEPTH
                && q_entries + 1 <= int'(cfg_msg_size)
                && q_chars + int'(r.len) <= int'(cfg_char_size);
            if (fits) begin
               tail = q_head + q_entries[4:0];
               q_handle[tail] = r.handle;
               q_len[tail] = r.len;
               q_entries++;
               q_chars += int'(r.len);
            end
            post_event(fits ? dtbs_pkg::KIND_ACCEPTED : dtbs_pkg::KIND_REJECTED,
                       '0, '0, 1'b1);
         end
         dtbs_pkg::OP_FLUSH: begin
            msg_tok = MSG_TOK_W'(refill_tokens(64'(msg_tok), 64'(cfg_msg_rate),
                                               64'(r.elapsed), 64'(cfg_msg_size)));
            char_tok = CHAR_TOK_W'(refill_tokens(64'(char_tok), 64'(cfg_char_rate),
                                                 64'(r.elapsed), 64'(cfg_char_size)));
            events = 0;
            // Drop oversize heads first
            while (events < MAX_EVENTS && q_entries > 0
                   && CHAR_SIZE_W'(q_len[q_head]) > cfg_char_burst) begin
               h = q_handle[q_head];
               l = q_len[q_head];
               q_chars -= int'(l);
               q_head++;
               q_entries--;
               post_event(dtbs_pkg::KIND_DROPPED, h, l, 1'b0);
               events++;
            end
            // Send heads while both buckets cover them
            while (events < MAX_EVENTS && q_entries > 0
                   && msg_tok >= dtbs_pkg::MSG_TOK_ONE) begin
               h = q_handle[q_head];
               l = q_len[q_head];
               cost = 64'(l) << FRAC_W;
               if (cost > 64'(char_tok))
                  break;
               msg_tok -= dtbs_pkg::MSG_TOK_ONE;
               char_tok -= CHAR_TOK_W'(cost);
               q_chars -= int'(l);
               q_head++;
               q_entries--;
               post_event(dtbs_pkg::KIND_SENT, h, l, 1'b0);
               events++;
            end
            post_event(dtbs_pkg::KIND_DONE, '0, '0, 1'b1);
         end
         default: begin
            q_head = '0;
            q_entries = 0;
            q_chars = 0;
            if (r.op == dtbs_pkg::OP_START) begin
               msg_tok = {cfg_msg_burst, {FRAC_W{1'b0}}};
               char_tok = {cfg_char_burst, {FRAC_W{1'b0}}};
            end
            post_event(dtbs_pkg::KIND_DONE, '0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Capture accepted requests and check accepted results
   always @(posedge clock) begin
      shaper_evt_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            reqs_accepted++;
            shape_request({req_op, req_msg_handle, req_msg_len, req_elapsed_ms});
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_events.size() == 0) begin
               $error("result with no prediction: kind %0d handle %0d len %0d",
                      rsp_kind, rsp_out_handle, rsp_out_len);
               mismatches++;
            end else begin
               want = predicted_events.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("out_handle", want.handle, rsp_out_handle);
               check_field("out_len", 32'(want.len), 32'(rsp_out_len));
               check_field("queued_count", 32'(want.queued), 32'(rsp_queued_count));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
      end
   end

   // Offer backlog requests; hold each one until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            staged_req = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_op <= staged_req.op;
            req_msg_handle <= staged_req.handle;
            req_msg_len <= staged_req.len;
            req_elapsed_ms <= staged_req.elapsed;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure, with one long hold-off to back up the input
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_spent && reqs_accepted >= HOLD_AT) begin
         hold_cycles = HOLD_LEN;
         hold_spent = 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic push_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                               input logic [LEN_W-1:0] len,
                               input logic [ELAPSED_W-1:0] elapsed);
      request_backlog.push_back({op, handle, len, elapsed});
      reqs_issued++;
   endtask

   task automatic wait_drained();
      while (reqs_accepted != reqs_issued || predicted_events.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dtbs_pkg::CSR_MSG_BUCKET_SIZE:  cfg_msg_size = data[MSG_SIZE_W-1:0];
         dtbs_pkg::CSR_CHAR_BUCKET_SIZE: cfg_char_size = data[CHAR_SIZE_W-1:0];
         dtbs_pkg::CSR_MSG_BURST:        cfg_msg_burst = data[MSG_SIZE_W-1:0];
         dtbs_pkg::CSR_CHAR_BURST:       cfg_char_burst = data[CHAR_SIZE_W-1:0];
         dtbs_pkg::CSR_MSG_RATE:         cfg_msg_rate = data[RATE_W-1:0];
         dtbs_pkg::CSR_CHAR_RATE:        cfg_char_rate = data[RATE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Let the block go idle, then load a full register set
   task automatic set_shaper(input int msg_size, input int char_size, input int msg_burst,
                             input int char_burst, input int msg_rate, input int char_rate);
      wait_drained();
      write_csr(dtbs_pkg::CSR_MSG_BUCKET_SIZE, CSR_DATA_W'(msg_size));
      write_csr(dtbs_pkg::CSR_CHAR_BUCKET_SIZE, CSR_DATA_W'(char_size));
      write_csr(dtbs_pkg::CSR_MSG_BURST, CSR_DATA_W'(msg_burst));
      write_csr(dtbs_pkg::CSR_CHAR_BURST, CSR_DATA_W'(char_burst));
      write_csr(dtbs_pkg::CSR_MSG_RATE, CSR_DATA_W'(msg_rate));
      write_csr(dtbs_pkg::CSR_CHAR_RATE, CSR_DATA_W'(char_rate));
      @(posedge clock);
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return LEN_W'($urandom_range(1, 64));
      else if (roll < 90)
         return LEN_W'($urandom_range(1, MAX_MSG_LEN));
      else if (roll < 95)
         return '0;
      else
         return LEN_W'($urandom_range(MAX_MSG_LEN + 1, 1023));
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return ELAPSED_W'($urandom_range(0, 15));
      else if (roll < 90)
         return ELAPSED_W'($urandom_range(0, 1000));
      else
         return ELAPSED_W'($urandom_range(0, 65535));
   endfunction

   // Mostly enqueue bursts closed by a flush; some starts and raw noise
   task automatic queue_traffic(input int n_items);
      int count;
      int roll;
      int burst;
      count = 0;
      while (count < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            burst = $urandom_range(1, 12);
            repeat (burst) push_request(dtbs_pkg::OP_ENQUEUE, $urandom, pick_len(),
                                        ELAPSED_W'($urandom));
            push_request(dtbs_pkg::OP_FLUSH, $urandom, LEN_W'($urandom), pick_elapsed());
            count += burst + 1;
         end else if (roll < 85) begin
            push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom),
                         ELAPSED_W'($urandom));
            count++;
         end else begin
            push_request(OP_W'($urandom_range(0, 3)), $urandom,
                         LEN_W'($urandom_range(0, 1023)), ELAPSED_W'($urandom));
            count++;
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 7;
      recv_idle_pct = 74;

      // Directed: length limits, oversize drop, char-limited send, all ops
      set_shaper(32, 65535, 2, 100, 0, 0);
      push_request(dtbs_pkg::OP_START, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF);
      push_request(dtbs_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 10'd512, 16'd0);
      push_request(dtbs_pkg::OP_ENQUEUE, 32'h0000_0000, 10'd1, 16'hFFFF);
      push_request(dtbs_pkg::OP_ENQUEUE, 32'hA5A5_A5A5, 10'd100, 16'd0);
      push_request(dtbs_pkg::OP_ENQUEUE, 32'h5A5A_5A5A, 10'd0, 16'd0);
      push_request(dtbs_pkg::OP_ENQUEUE, 32'h1234_5678, 10'd513, 16'd0);
      push_request(dtbs_pkg::OP_ENQUEUE, 32'h8765_4321, 10'h3FF, 16'd0);
      push_request(dtbs_pkg::OP_FLUSH, 32'hFFFF_FFFF, 10'h3FF, 16'd0);
      push_request(dtbs_pkg::OP_FLUSH, 32'd0, 10'd0, 16'hFFFF);
      push_request(dtbs_pkg::OP_CLEAR, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF);
      push_request(dtbs_pkg::OP_FLUSH, 32'd0, 10'd0, 16'd0);

      // Widest settings: fill the queue past its depth and flush it whole
      set_shaper(32, 65535, 32, 65535, 24'hFF_FFFF, 24'hFF_FFFF);
      push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom), ELAPSED_W'($urandom));
      repeat (QDEPTH + 1)
         push_request(dtbs_pkg::OP_ENQUEUE, $urandom,
                      LEN_W'($urandom_range(1, MAX_MSG_LEN)), ELAPSED_W'($urandom));
      push_request(dtbs_pkg::OP_FLUSH, $urandom, LEN_W'($urandom), 16'd1);
      queue_traffic(40);

      // Zero everywhere: every enqueue is refused
      set_shaper(0, 0, 0, 0, 0, 0);
      push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom), ELAPSED_W'($urandom));
      queue_traffic(20);

      send_idle_pct = 74;
      recv_idle_pct = 7;
      set_shaper(8, 2000, 2, 300, 65, 6554);
      push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom), ELAPSED_W'($urandom));
      queue_traffic(85);

      set_shaper($urandom_range(0, 32), $urandom_range(256, 8192), $urandom_range(0, 32),
                 $urandom_range(0, 1024), $urandom_range(0, 1 << 18),
                 $urandom_range(0, 1 << 24));
      push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom), ELAPSED_W'($urandom));
      queue_traffic(85);

      // Bursts above the bucket sizes until the first refill caps them
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_shaper(4, 1000, 32, 65535, 1000, 200000);
      push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom), ELAPSED_W'($urandom));
      queue_traffic(85);

      set_shaper($urandom_range(0, 32), $urandom_range(256, 8192), $urandom_range(0, 32),
                 $urandom_range(0, 1024), $urandom_range(0, 1 << 18),
                 $urandom_range(0, 1 << 24));
      push_request(dtbs_pkg::OP_START, $urandom, LEN_W'($urandom), ELAPSED_W'($urandom));
      queue_traffic(85);

      wait_drained();
      repeat (80) @(negedge clock);
      if (mismatches == 0 && predicted_events.size() == 0) begin
         $display("dual_token_bucket_shaper verification clean");
      end else begin
         $display("dual_token_bucket_shaper verification failed");
      end
      $finish;
   end

endmodule
